FILE: src/imr_pkg.sv
// Shared types and constants for the int8 matmul/requantize block.
// No dependencies; every other file except imr_ram refers here by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package imr_pkg;

    // Item kind carried on the slave-side tuser
    typedef enum logic [1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_BIAS   = 2'd1,
        CMD_ACT    = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_Q_RD,
        ST_Q_MUL,
        ST_Q_RND,
        ST_Q_OUT
    } t_state;

    // Configuration register indexes
    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_SHIFT = 1'b1;

    localparam int CMD_W       = 2;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 4;
    localparam int SMALL_W     = 8;
    localparam int BIAS_W      = 32;
    localparam int ACC_W       = 32;
    localparam int PROD_W      = 64;
    localparam int SHIFT_W     = 6;
    localparam int VALUE_W     = 16;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    localparam logic signed [ACC_W-1:0] SCALE_RESET = 32'sd32768;
    localparam logic [SHIFT_W-1:0]      SHIFT_RESET = 6'd15;

    localparam logic [PROD_W-1:0]  SAT_POS_MAG = 64'd32767;
    localparam logic [PROD_W-1:0]  SAT_NEG_MAG = 64'd32768;
    localparam logic [VALUE_W-1:0] SAT_POS_VAL = 16'h7FFF;
    localparam logic [VALUE_W-1:0] SAT_NEG_VAL = 16'h8000;

    // Sequencer to datapath controls
    typedef struct packed {
        logic act_load;   // capture activation on its transfer
        logic sel_acc;    // multiplier takes accumulator x scale
        logic acc_we;     // write back accumulator
        logic use_bias;   // first reduction step starts from bias
        logic round_en;   // capture rounded magnitude
        logic out_load;   // load output register
        logic out_last;   // last column of the row
    } t_ctrl;

endpackage

`default_nettype wire

FILE: src/imr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module imr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/imr_mul.sv
// Shared signed 32x32 multiplier with registered 64-bit product.
// Used for both the MAC step and the requantize scaling.
`timescale 1ns / 1ps
`default_nettype none

module imr_mul (
    input  logic                                 i_clk,
    input  logic signed [imr_pkg::ACC_W-1:0]     i_a,
    input  logic signed [imr_pkg::ACC_W-1:0]     i_b,
    output logic signed [imr_pkg::PROD_W-1:0]    o_prod
);

    logic signed [imr_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: src/imr_requant.sv
// Requantize back end: magnitude plus rounding term (registered), then
// variable right shift and int16 saturation. Uses imr_pkg constants.
`timescale 1ns / 1ps
`default_nettype none

module imr_requant (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [imr_pkg::PROD_W-1:0]    i_prod,
    input  logic [imr_pkg::SHIFT_W-1:0]          i_shift,
    output logic [imr_pkg::VALUE_W-1:0]          o_value
);

    logic [imr_pkg::PROD_W-1:0] add_in;
    logic [imr_pkg::PROD_W-1:0] rnd;
    logic [imr_pkg::PROD_W-1:0] n_sum;
    logic [imr_pkg::PROD_W-1:0] shifted;
    logic [imr_pkg::PROD_W-1:0] r_sum;
    logic                       r_neg;

    // |prod| + rnd as one add: -p = ~p + 1, the +1 rides along with rnd
    always_comb begin
        rnd     = (i_shift == '0) ? '0 : (64'd1 << (i_shift - 6'd1));
        add_in  = i_prod[imr_pkg::PROD_W-1] ? ~i_prod : i_prod;
        n_sum   = add_in + rnd + 64'(i_prod[imr_pkg::PROD_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
            r_neg <= i_prod[imr_pkg::PROD_W-1];
        end
    end

    always_comb begin
        shifted = r_sum >> i_shift;
        if (r_neg) begin
            o_value = (shifted > imr_pkg::SAT_NEG_MAG) ? imr_pkg::SAT_NEG_VAL
                                                       : 16'(16'd0 - shifted[15:0]);
        end else begin
            o_value = (shifted > imr_pkg::SAT_POS_MAG) ? imr_pkg::SAT_POS_VAL
                                                       : shifted[15:0];
        end
    end

endmodule

`default_nettype wire

FILE: src/imr_seq.sv
// Sequencer: idle/load handling, per-activation column sweep through the
// shared multiplier, and per-column requantize steps. Uses imr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imr_seq #(
    parameter int DEPTH_K   = 64,
    parameter int COLUMNS_N = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    input  logic [imr_pkg::CMD_W-1:0]                    i_cmd,
    input  logic                                         i_out_free,
    output logic                                         o_ready,
    output imr_pkg::t_ctrl                               o_ctrl,
    output logic [(DEPTH_K > 1 ? $clog2(DEPTH_K) : 1)-1:0]     o_row,
    output logic [(COLUMNS_N > 1 ? $clog2(COLUMNS_N) : 1)-1:0] o_wcol,
    output logic [(COLUMNS_N > 1 ? $clog2(COLUMNS_N) : 1)-1:0] o_acc_rcol,
    output logic [(COLUMNS_N > 1 ? $clog2(COLUMNS_N) : 1)-1:0] o_acc_wcol,
    output logic [(COLUMNS_N > 1 ? $clog2(COLUMNS_N) : 1)-1:0] o_out_col
);

    localparam int KW = (DEPTH_K > 1) ? $clog2(DEPTH_K) : 1;
    localparam int CW = (COLUMNS_N > 1) ? $clog2(COLUMNS_N) : 1;
    localparam int SW = $clog2(COLUMNS_N + 2);

    imr_pkg::t_state r_state, n_state;
    logic [KW-1:0]   r_row, n_row;
    logic [SW-1:0]   r_step, n_step;
    logic [CW-1:0]   r_col, n_col;

    logic v1, v2, step_last, row_last, col_last;

    // Sweep pipeline: step s issues weight read for column s, multiplies
    // column s-1, writes back column s-2.
    assign v1        = (r_step != '0) && (r_step <= SW'(COLUMNS_N));
    assign v2        = (r_step >= SW'(2));
    assign step_last = (r_step == SW'(COLUMNS_N + 1));
    assign row_last  = (r_row == KW'(DEPTH_K - 1));
    assign col_last  = (r_col == CW'(COLUMNS_N - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imr_pkg::ST_IDLE;
            r_row   <= '0;
            r_step  <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_step  <= n_step;
            r_col   <= n_col;
        end
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_step  = r_step;
        n_col   = r_col;
        o_ctrl  = '0;
        case (r_state)
            imr_pkg::ST_IDLE: begin
                if (i_in_valid && (i_cmd == imr_pkg::CMD_ACT)) begin
                    o_ctrl.act_load = 1'b1;
                    n_step          = '0;
                    n_state         = imr_pkg::ST_MAC;
                end
            end
            imr_pkg::ST_MAC: begin
                o_ctrl.acc_we   = v2;
                o_ctrl.use_bias = (r_row == '0);
                if (step_last) begin
                    n_step = '0;
                    if (row_last) begin
                        n_row   = '0;
                        n_col   = '0;
                        n_state = imr_pkg::ST_Q_RD;
                    end else begin
                        n_row   = r_row + KW'(1);
                        n_state = imr_pkg::ST_IDLE;
                    end
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            imr_pkg::ST_Q_RD: begin
                n_state = imr_pkg::ST_Q_MUL;
            end
            imr_pkg::ST_Q_MUL: begin
                o_ctrl.sel_acc = 1'b1;
                n_state        = imr_pkg::ST_Q_RND;
            end
            imr_pkg::ST_Q_RND: begin
                o_ctrl.round_en = 1'b1;
                n_state         = imr_pkg::ST_Q_OUT;
            end
            imr_pkg::ST_Q_OUT: begin
                if (i_out_free) begin
                    o_ctrl.out_load = 1'b1;
                    o_ctrl.out_last = col_last;
                    if (col_last) begin
                        n_col   = '0;
                        n_state = imr_pkg::ST_IDLE;
                    end else begin
                        n_col   = r_col + CW'(1);
                        n_state = imr_pkg::ST_Q_RD;
                    end
                end
            end
            default: begin
                n_state = imr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_ready    = (r_state == imr_pkg::ST_IDLE);
    assign o_row      = r_row;
    assign o_wcol     = (r_step < SW'(COLUMNS_N)) ? CW'(r_step) : '0;
    assign o_acc_rcol = (r_state == imr_pkg::ST_MAC) ? (v1 ? CW'(r_step - SW'(1)) : '0)
                                                     : r_col;
    assign o_acc_wcol = CW'(r_step - SW'(2));
    assign o_out_col  = r_col;

endmodule

`default_nettype wire

FILE: src/int8_matmul_requantize.sv
// Top level: int8 matrix-vector product with bias and int16 requantization.
// Depends on imr_pkg, imr_ram, imr_mul, imr_requant, imr_seq.
//
//  channel  | direction | transfer               | payload
//  ---------+-----------+------------------------+----------------------------------
//  s_*      | in        | s_tvalid & s_tready    | tuser: command; tdata: row, col,
//           |           |                        |   small value, bias word
//  m_*      | out       | m_tvalid & m_tready    | tdata: value, column; tlast: row end
//  i_cfg_*  | in        | i_cfg_we               | index 0 scale_factor, 1 right_shift
//
// Weight and bias loads keep s_tready high. An activation sweeps all
// COLUMNS_N columns, one column per cycle, through the shared multiplier and
// then drains the multiplier pipeline. After the DEPTH_K-th activation each
// result goes through read, multiply, round, then shift and saturate, using the
// same multiplier; the output step waits while the master side stalls.
// Reset is synchronous: it clears sequencer, counters, output valid and sets
// the configuration registers; weight, bias and accumulator RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module int8_matmul_requantize #(
    parameter int DEPTH_K   = 64,
    parameter int COLUMNS_N = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [5:0] weight_row, [9:6] column_index, [17:10] small_value,
    // [49:18] bias_value, [55:50] zero
    input  logic [imr_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [1:0] command
    input  logic [imr_pkg::CMD_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] out_value, [19:16] out_column, [23:20] zero
    output logic [imr_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [imr_pkg::ACC_W-1:0]           i_cfg_data
);

    localparam int KW     = (DEPTH_K > 1) ? $clog2(DEPTH_K) : 1;
    localparam int CW     = (COLUMNS_N > 1) ? $clog2(COLUMNS_N) : 1;
    localparam int WDEPTH = DEPTH_K * COLUMNS_N;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    // Input fields
    logic [imr_pkg::ROW_W-1:0]   in_row;
    logic [imr_pkg::COL_W-1:0]   in_col;
    logic [imr_pkg::SMALL_W-1:0] in_small;
    logic [imr_pkg::BIAS_W-1:0]  in_bias;

    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[9:6];
    assign in_small = s_tdata[17:10];
    assign in_bias  = s_tdata[49:18];

    logic accept, row_ok, col_ok;
    logic w_we, b_we;
    logic [WAW-1:0] w_waddr, w_raddr;
    logic [CW-1:0]  b_waddr;

    imr_pkg::t_ctrl ctrl;
    logic [KW-1:0]  seq_row;
    logic [CW-1:0]  seq_wcol, seq_acc_rcol, seq_acc_wcol, seq_out_col;

    logic [imr_pkg::SMALL_W-1:0]        w_rdata;
    logic [imr_pkg::ACC_W-1:0]          b_rdata, acc_rdata, acc_wdata;
    logic signed [imr_pkg::ACC_W-1:0]   mul_a, mul_b;
    logic signed [imr_pkg::PROD_W-1:0]  prod;
    logic [imr_pkg::VALUE_W-1:0]        rq_value;

    logic signed [imr_pkg::ACC_W-1:0]   r_scale;
    logic [imr_pkg::SHIFT_W-1:0]        r_shift;
    logic [imr_pkg::SMALL_W-1:0]        r_act;
    logic                               r_m_valid;
    logic                               r_m_last;
    logic [imr_pkg::VALUE_W-1:0]        r_m_value;
    logic [imr_pkg::COL_W-1:0]          r_m_col;
    logic                               out_free;

    assign accept  = s_tvalid && s_tready;
    assign row_ok  = (32'(in_row) < DEPTH_K);
    assign col_ok  = (32'(in_col) < COLUMNS_N);
    assign w_we    = accept && (s_tuser == imr_pkg::CMD_WEIGHT) && row_ok && col_ok;
    assign b_we    = accept && (s_tuser == imr_pkg::CMD_BIAS) && col_ok;
    assign w_waddr = WAW'(32'(in_row) * COLUMNS_N + 32'(in_col));
    assign b_waddr = CW'(in_col);
    assign w_raddr = WAW'(32'(seq_row) * COLUMNS_N + 32'(seq_wcol));

    assign out_free = !r_m_valid || m_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= imr_pkg::SCALE_RESET;
            r_shift <= imr_pkg::SHIFT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                imr_pkg::CFG_SCALE: r_scale <= i_cfg_data;
                imr_pkg::CFG_SHIFT: r_shift <= i_cfg_data[imr_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.act_load) begin
            r_act <= in_small;
        end
    end

    imr_seq #(
        .DEPTH_K   (DEPTH_K),
        .COLUMNS_N (COLUMNS_N)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_cmd      (s_tuser),
        .i_out_free (out_free),
        .o_ready    (s_tready),
        .o_ctrl     (ctrl),
        .o_row      (seq_row),
        .o_wcol     (seq_wcol),
        .o_acc_rcol (seq_acc_rcol),
        .o_acc_wcol (seq_acc_wcol),
        .o_out_col  (seq_out_col)
    );

    imr_ram #(
        .WIDTH (imr_pkg::SMALL_W),
        .DEPTH (WDEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (in_small),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    imr_ram #(
        .WIDTH (imr_pkg::BIAS_W),
        .DEPTH (COLUMNS_N)
    ) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (in_bias),
        .i_raddr (seq_acc_rcol),
        .o_rdata (b_rdata)
    );

    imr_ram #(
        .WIDTH (imr_pkg::ACC_W),
        .DEPTH (COLUMNS_N)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.acc_we),
        .i_waddr (seq_acc_wcol),
        .i_wdata (acc_wdata),
        .i_raddr (seq_acc_rcol),
        .o_rdata (acc_rdata)
    );

    // Multiplier operands: activation x weight during the sweep,
    // accumulator x scale during requantize
    assign mul_a = ctrl.sel_acc ? acc_rdata
                                : {{(imr_pkg::ACC_W - imr_pkg::SMALL_W){r_act[7]}}, r_act};
    assign mul_b = ctrl.sel_acc ? r_scale
                                : {{(imr_pkg::ACC_W - imr_pkg::SMALL_W){w_rdata[7]}}, w_rdata};

    imr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // 32-bit wrapping accumulate
    assign acc_wdata = (ctrl.use_bias ? b_rdata : acc_rdata) + prod[imr_pkg::ACC_W-1:0];

    imr_requant u_requant (
        .i_clk   (i_clk),
        .i_en    (ctrl.round_en),
        .i_prod  (prod),
        .i_shift (r_shift),
        .o_value (rq_value)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_m_value <= rq_value;
            r_m_col   <= imr_pkg::COL_W'(seq_out_col);
            r_m_last  <= ctrl.out_last;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tlast  = r_m_last;
    assign m_tdata  = {4'b0, r_m_col, r_m_value};

endmodule

`default_nettype wire

FILE: src/imr_checker.sv
// Port-level checker for int8_matmul_requantize, attached by bind.
// Depends on imr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imr_checker #(
    parameter int COLUMNS_N = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [imr_pkg::CMD_W-1:0]         s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [imr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                              m_tlast
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Out of reset: ready for input, nothing pending on the output
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> s_tready && !m_tvalid)
        else $error("bad state after reset");

    // An activation occupies the block for its column sweep
    a_act_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && (s_tuser == imr_pkg::CMD_ACT) |=> !s_tready)
        else $error("ready right after activation transfer");

    // Loads and unused commands leave the input ready for the next transfer
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && (s_tuser != imr_pkg::CMD_ACT) |=> s_tready)
        else $error("ready dropped after load transfer");

    // Row end marks the last column
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> (m_tdata[19:16] == 4'(COLUMNS_N - 1)))
        else $error("tlast on wrong column");

endmodule

bind int8_matmul_requantize imr_checker #(
    .COLUMNS_N (COLUMNS_N)
) u_imr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
